// ----- hdl/ptds_pkg.sv -----
package ptds_pkg;

   localparam int MAX_TASKS_DEF = 8;
   localparam int TIME_W        = 32;
   localparam int TASK_IDX_W    = 3;
   localparam int ENTRY_W       = 2 * TIME_W;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NULL = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

endpackage

// ----- hdl/ptds_req_if.sv -----
interface ptds_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic                         handler_present;
   logic [ptds_pkg::TIME_W-1:0]  period_ticks;
   logic [ptds_pkg::TIME_W-1:0]  now_ms;

   modport source (output valid, kind, handler_present, period_ticks, now_ms, input ready);
   modport sink   (input valid, kind, handler_present, period_ticks, now_ms, output ready);
endinterface

// ----- hdl/ptds_rsp_if.sv -----
interface ptds_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic                             fired;
   logic [ptds_pkg::TASK_IDX_W-1:0]  task_index;
   logic                             last;

   modport source (output valid, status, fired, task_index, last, input ready);
   modport sink   (input valid, status, fired, task_index, last, output ready);
endinterface

// ----- hdl/periodic_task_due_scheduler_unit.sv -----
// channel   | interface          | direction | carries
// ----------+--------------------+-----------+---------------------------------------------
// req_chan  | ptds_req_if.sink   | in        | kind, handler_present, period_ticks, now_ms
// rsp_chan  | ptds_rsp_if.source | out       | status, fired, task_index, last
//
// an add passes through the add state, which writes its result to the output register
// once that register is free
// a scan reads one table entry per cycle unless stalled; the table read is registered,
// and a close-out step writes the last result before the unit returns to idle
// reset clears the task count and control state; the task memory is not cleared
// a full output register stalls the scan when a further due task is found; one new
// transaction is taken only after the previous one has finished, while its last result
// may still wait
module periodic_task_due_scheduler_unit #(
   parameter int MAX_TASKS = ptds_pkg::MAX_TASKS_DEF
) (
   input logic        clock,
   input logic        reset,
   ptds_req_if.sink   req_chan,
   ptds_rsp_if.source rsp_chan
);
   import ptds_pkg::*;

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TASKS);

   typedef enum logic [1:0] {S_IDLE, S_ADD, S_SCAN} state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               ev_valid_ff, ev_valid_in;
   logic [IW-1:0]      ev_idx_ff, ev_idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [IW-1:0]      pend_idx_ff, pend_idx_in;
   logic               handler_ff, handler_in;
   logic [TIME_W-1:0]  period_ff, period_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               out_valid_ff, out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic               out_fired_ff, out_fired_in;
   logic [TASK_IDX_W-1:0] out_index_ff, out_index_in;
   logic               out_last_ff, out_last_in;

   logic               out_free;
   logic [ENTRY_W-1:0] rd_data;
   logic [TIME_W-1:0]  rd_period;
   logic [TIME_W-1:0]  rd_last;
   logic               due;
   logic               stall;
   logic               issue;
   logic               scan_done;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               add_ok;

   ptds_mem #(
      .DEPTH  (MAX_TASKS),
      .ADDR_W (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign rd_period = rd_data[ENTRY_W-1:TIME_W];
   assign rd_last   = rd_data[TIME_W-1:0];
   assign due       = ev_valid_ff &&
                      ((rd_period == '0) || ((now_ff - rd_last) >= rd_period));
   // a second due task needs the output register to push out the pending one
   assign stall     = due && pend_valid_ff && !out_free;
   assign issue     = scan_idx_ff < count_ff;
   assign scan_done = (state_ff == S_SCAN) && !ev_valid_ff && !issue;
   // on a stall, read the held entry again so the read data stays put
   assign rd_addr   = stall ? ev_idx_ff : scan_idx_ff[IW-1:0];
   assign add_ok    = handler_ff && (count_ff < COUNT_MAX);

   assign wr_en   = ((state_ff == S_ADD) && out_free && add_ok) ||
                    ((state_ff == S_SCAN) && due && !stall);
   assign wr_addr = (state_ff == S_ADD) ? count_ff[IW-1:0] : ev_idx_ff;
   assign wr_data = (state_ff == S_ADD) ? {period_ff, {TIME_W{1'b0}}}
                                        : {rd_period, now_ff};

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = out_status_ff;
   assign rsp_chan.fired      = out_fired_ff;
   assign rsp_chan.task_index = out_index_ff;
   assign rsp_chan.last       = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      handler_in    = handler_ff;
      period_in     = period_ff;
      now_in        = now_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_fired_in  = out_fired_ff;
      out_index_in  = out_index_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               handler_in = req_chan.handler_present;
               period_in  = req_chan.period_ticks;
               now_in     = req_chan.now_ms;
               if (req_chan.kind == KIND_ADD) begin
                  state_in = S_ADD;
               end else begin
                  state_in      = S_SCAN;
                  scan_idx_in   = '0;
                  ev_valid_in   = 1'b0;
                  pend_valid_in = 1'b0;
               end
            end
         end
         S_ADD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_fired_in = 1'b0;
               out_last_in  = 1'b1;
               out_index_in = '0;
               if (!handler_ff) begin
                  out_status_in = STATUS_NULL;
               end else if (!add_ok) begin
                  out_status_in = STATUS_FULL;
               end else begin
                  out_status_in = STATUS_OK;
                  out_index_in  = TASK_IDX_W'(count_ff);
                  count_in      = count_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_status_in = STATUS_OK;
                  out_fired_in  = pend_valid_ff;
                  out_index_in  = pend_valid_ff ? TASK_IDX_W'(pend_idx_ff) : '0;
                  out_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = S_IDLE;
               end
            end else if (!stall) begin
               if (due) begin
                  pend_valid_in = 1'b1;
                  pend_idx_in   = ev_idx_ff;
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_status_in = STATUS_OK;
                     out_fired_in  = 1'b1;
                     out_index_in  = TASK_IDX_W'(pend_idx_ff);
                     out_last_in   = 1'b0;
                  end
               end
               if (issue) begin
                  ev_valid_in = 1'b1;
                  ev_idx_in   = scan_idx_ff[IW-1:0];
                  scan_idx_in = scan_idx_ff + 1'b1;
               end else begin
                  ev_valid_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         scan_idx_ff   <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_idx_ff   <= scan_idx_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      ev_idx_ff     <= ev_idx_in;
      pend_idx_ff   <= pend_idx_in;
      handler_ff    <= handler_in;
      period_ff     <= period_in;
      now_ff        <= now_in;
      out_status_ff <= out_status_in;
      out_fired_ff  <= out_fired_in;
      out_index_ff  <= out_index_in;
      out_last_ff   <= out_last_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("task count above table size");

   a_eval_in_table: assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff |-> ({1'b0, ev_idx_ff} < {1'b0, count_ff}))
      else $error("evaluated entry beyond task count");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!pend_valid_ff && !ev_valid_ff && !wr_en))
      else $error("scan state left over in idle");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> (ev_valid_ff && (ev_idx_ff == $past(ev_idx_ff)) && pend_valid_ff))
      else $error("scan advanced during output stall");

endmodule

// ----- hdl/ptds_mem.sv -----
module ptds_mem #(
   parameter int DEPTH  = ptds_pkg::MAX_TASKS_DEF,
   parameter int ADDR_W = 3
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [ptds_pkg::ENTRY_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [ptds_pkg::ENTRY_W-1:0]  rd_data
);
   import ptds_pkg::*;

   // entry = {period, last fire time}
   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sim/ptds_due_checker.sv -----
module ptds_due_checker #(
   parameter int MAX_TASKS = ptds_pkg::MAX_TASKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ptds_req_if         req_mon,
   ptds_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);
   import ptds_pkg::*;

   typedef struct {
      status_type            status;
      logic                  fired;
      logic [TASK_IDX_W-1:0] task_index;
      logic                  last;
   } due_result_type;

   due_result_type      due_queue[$];
   logic [TIME_W-1:0]   period_tab[MAX_TASKS];
   logic [TIME_W-1:0]   last_fire_tab[MAX_TASKS];
   int                  task_total = 0;
   int unsigned         miscompares = 0;
   int unsigned         pending_q = 0;

   assign mismatch_count = miscompares;
   assign pending_count  = pending_q;

   task automatic push_result(input status_type status, input logic fired,
                              input logic [TASK_IDX_W-1:0] index, input logic last);
      due_result_type r;
      r.status     = status;
      r.fired      = fired;
      r.task_index = index;
      r.last       = last;
      due_queue.push_back(r);
   endtask

   task automatic predict_schedule(input logic kind, input logic handler_present,
                                   input logic [TIME_W-1:0] period,
                                   input logic [TIME_W-1:0] now);
      int                i;
      int                fired_total;
      logic [TIME_W-1:0] elapsed;
      fired_total = 0;
      if (kind == KIND_ADD) begin
         if (!handler_present) begin
            push_result(STATUS_NULL, 1'b0, '0, 1'b1);
         end else if (task_total >= MAX_TASKS) begin
            push_result(STATUS_FULL, 1'b0, '0, 1'b1);
         end else begin
            period_tab[task_total]    = period;
            last_fire_tab[task_total] = '0;
            push_result(STATUS_OK, 1'b0, task_total[TASK_IDX_W-1:0], 1'b1);
            task_total++;
         end
      end else begin
         for (i = 0; i < task_total; i++) begin
            // elapsed time wraps modulo 2^32
            elapsed = now - last_fire_tab[i];
            if (period_tab[i] == '0 || elapsed >= period_tab[i]) begin
               last_fire_tab[i] = now;
               push_result(STATUS_OK, 1'b1, i[TASK_IDX_W-1:0], 1'b0);
               fired_total++;
            end
         end
         if (fired_total == 0)
            push_result(STATUS_OK, 1'b0, '0, 1'b1);
         else
            due_queue[$].last = 1'b1;
      end
   endtask

   task automatic check_result();
      due_result_type want;
      if (due_queue.size() == 0) begin
         if (miscompares < 10)
            $display("unexpected result: status=%0d fired=%0b task_index=%0d last=%0b",
                     rsp_mon.status, rsp_mon.fired, rsp_mon.task_index, rsp_mon.last);
         miscompares++;
      end else begin
         want = due_queue.pop_front();
         if (rsp_mon.status !== want.status || rsp_mon.fired !== want.fired ||
             rsp_mon.task_index !== want.task_index || rsp_mon.last !== want.last) begin
            if (miscompares < 10)
               $display({"result differs: expected status=%0d fired=%0b task_index=%0d ",
                         "last=%0b, got status=%0d fired=%0b task_index=%0d last=%0b"},
                        want.status, want.fired, want.task_index, want.last,
                        rsp_mon.status, rsp_mon.fired, rsp_mon.task_index, rsp_mon.last);
            miscompares++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_queue.delete();
         task_total = 0;
         pending_q <= 0;
      end else begin
         // results accepted at this edge belong to older transactions
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
         if (req_mon.valid && req_mon.ready)
            predict_schedule(req_mon.kind, req_mon.handler_present,
                             req_mon.period_ticks, req_mon.now_ms);
         pending_q <= due_queue.size();
      end
   end

endmodule

// ----- sim/periodic_task_due_scheduler_unit_test.sv -----
module periodic_task_due_scheduler_unit_test;
   import ptds_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int ITEM_TOTAL = 130;

   typedef enum logic [1:0] {
      RDY_OPEN,
      RDY_COIN,
      RDY_CHOKE,
      RDY_PULSE
   } ready_mode_type;

   logic           clock;
   logic           reset;
   int unsigned    mismatches;
   int unsigned    pending;
   int unsigned    burst_left = 0;
   int unsigned    idle_cycles = 0;
   ready_mode_type ready_mode = RDY_OPEN;
   int unsigned    ready_left = 0;

   ptds_req_if req_if();
   ptds_rsp_if rsp_if();

   periodic_task_due_scheduler_unit #(
      .MAX_TASKS(MAX_TASKS_DEF)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   ptds_due_checker #(
      .MAX_TASKS(MAX_TASKS_DEF)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .mismatch_count(mismatches),
      .pending_count (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(8, 48);
      end else begin
         ready_left--;
      end
      case (ready_mode)
         RDY_OPEN:  rsp_if.ready <= 1'b1;
         RDY_COIN:  rsp_if.ready <= ($urandom_range(0, 1) == 1);
         RDY_CHOKE: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         default:   rsp_if.ready <= ((ready_left % 6) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("periodic_task_due_scheduler_unit: mismatch");
            $finish;
         end
      end
   end

   task automatic post_request(input logic kind, input logic handler_present,
                               input logic [TIME_W-1:0] period,
                               input logic [TIME_W-1:0] now);
      int unsigned gap;
      req_if.valid           <= 1'b1;
      req_if.kind            <= kind;
      req_if.handler_present <= handler_present;
      req_if.period_ticks    <= period;
      req_if.now_ms          <= now;
      do @(posedge clock); while (!req_if.ready);
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 10);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic add_task(input logic handler_present, input logic [TIME_W-1:0] period);
      post_request(KIND_ADD, handler_present, period, $urandom);
   endtask

   task automatic scan_at(input logic [TIME_W-1:0] now);
      post_request(KIND_SCAN, 1'($urandom_range(0, 1)), $urandom, now);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      logic [TIME_W-1:0] now_tick;
      int unsigned       pick;
      int                n;

      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.kind            <= KIND_ADD;
      req_if.handler_present <= 1'b0;
      req_if.period_ticks    <= '0;
      req_if.now_ms          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // scan of an empty table, null handler, then a partly filled table
      scan_at(32'h0000_0000);
      add_task(1'b0, 32'h0000_0005);
      add_task(1'b1, 32'h0000_0000);
      add_task(1'b1, 32'hFFFF_FFFF);
      add_task(1'b1, 32'h0000_0001);
      add_task(1'b1, 32'h0000_0003);
      scan_at(32'h0000_0000);
      scan_at(32'hFFFF_FFFF);
      scan_at(32'h0000_0000);   // wrap across zero
      scan_at(32'h0000_0001);
      add_task(1'b1, 32'h0000_000A);
      add_task(1'b1, 32'h8000_0000);
      add_task(1'b1, 32'h0000_0019);
      add_task(1'b1, 32'h0000_0007);
      add_task(1'b1, 32'h0000_0002);   // table full
      add_task(1'b0, 32'h0000_0002);   // null wins over full
      scan_at(32'h8000_0010);
      scan_at(32'h8000_0011);
      drain_results();

      now_tick = 32'h8000_0011;
      for (n = 0; n < ITEM_TOTAL; n++) begin
         if (n == ITEM_TOTAL / 2)
            drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            add_task(1'($urandom_range(0, 1)), $urandom);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               now_tick = now_tick + $urandom_range(0, 12);
            else if (pick < 85)
               now_tick = now_tick + $urandom_range(0, 40);
            else if (pick < 95)
               now_tick = now_tick + $urandom;
            else
               now_tick = $urandom;
            scan_at(now_tick);
         end
      end

      drain_results();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("periodic_task_due_scheduler_unit: match");
      else
         $display("periodic_task_due_scheduler_unit: mismatch");
      $finish;
   end

endmodule
